FILE: rtl/core/text_glyph_blit_commands_defines.svh
// ----------------------------------------------------------------------------
// text glyph blitter assertion macros
// shared property wrappers for the blitter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef TEXT_GLYPH_BLIT_COMMANDS_DEFINES_SVH
`define TEXT_GLYPH_BLIT_COMMANDS_DEFINES_SVH

// same-cycle implication
`define TGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgb check failed");

// next-cycle implication
`define TGB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgb check failed");

`endif

FILE: rtl/core/tgb_pkg.sv
// ----------------------------------------------------------------------------
// tgb_pkg
// types and fixed constants of the text glyph blitter
// ----------------------------------------------------------------------------
package tgb_pkg;

  localparam int CH_W     = 8;
  localparam int XY_W     = 12;
  localparam int DIM_W    = 6;
  localparam int STRIDE_W = 13;
  localparam int DEST_W   = 24;
  localparam int SRC_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int GLYPH_IDX_W = 7;
  localparam int SRC1_W   = GLYPH_IDX_W + DIM_W;

  localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CH_W-1:0] CH_SPACE   = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd2;

  localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE  = 13'd640;
  localparam logic [DIM_W-1:0]    RST_GLYPH_WIDTH  = 6'd8;
  localparam logic [DIM_W-1:0]    RST_GLYPH_HEIGHT = 6'd16;

  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_DAMAGE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CALC,
    ST_ROWS,
    ST_DAMAGE
  } state_t;

  typedef struct packed {
    logic cap;    // capture input word
    logic setup;  // apply string start, first multiply
    logic calc;   // second multiply, newline update
    logic row;    // load a row copy word
    logic adv;    // advance cursor after a glyph
    logic dmg;    // load the damage word
  } cmd_t;

  typedef struct packed {
    logic printable;
    logic newline;
    logic gh_zero;
    logic last_row;
    logic last_str;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/tgb_ctrl.sv
// ----------------------------------------------------------------------------
// tgb_ctrl
// sequencer for the text glyph blitter
// ----------------------------------------------------------------------------
`include "text_glyph_blit_commands_defines.svh"

module tgb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tgb_pkg::stat_t stat,
  output tgb_pkg::cmd_t  cmd
);

  tgb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tgb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tgb_pkg::ST_SETUP;
      end
      tgb_pkg::ST_SETUP: begin
        state_nxt = tgb_pkg::ST_CALC;
      end
      tgb_pkg::ST_CALC: begin
        if (stat.printable && !stat.gh_zero) begin
          state_nxt = tgb_pkg::ST_ROWS;
        end else if (stat.last_str) begin
          state_nxt = tgb_pkg::ST_DAMAGE;
        end else begin
          state_nxt = tgb_pkg::ST_IDLE;
        end
      end
      tgb_pkg::ST_ROWS: begin
        if (stat.out_free && stat.last_row) begin
          state_nxt = stat.last_str ? tgb_pkg::ST_DAMAGE : tgb_pkg::ST_IDLE;
        end
      end
      tgb_pkg::ST_DAMAGE: begin
        if (stat.out_free) state_nxt = tgb_pkg::ST_IDLE;
      end
      default: state_nxt = tgb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      tgb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      tgb_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      tgb_pkg::ST_CALC: begin
        cmd.calc = 1'b1;
        // zero-height glyph still moves the cursor
        cmd.adv  = stat.printable && stat.gh_zero;
      end
      tgb_pkg::ST_ROWS: begin
        cmd.row = stat.out_free;
        cmd.adv = stat.out_free && stat.last_row;
      end
      tgb_pkg::ST_DAMAGE: begin
        cmd.dmg = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `TGB_ASSERT_IMP(a_load_needs_slot, clk, rst_n, cmd.row || cmd.dmg, stat.out_free)
  `TGB_ASSERT_IMP(a_single_load, clk, rst_n, cmd.row, !cmd.dmg)
  `TGB_ASSERT_NXT(a_cap_then_setup, clk, rst_n, cmd.cap, cmd.setup)
  `TGB_ASSERT_IMP(a_adv_placed, clk, rst_n, cmd.adv, (cmd.row && stat.last_row) || cmd.calc)

endmodule

FILE: rtl/core/tgb_datapath.sv
// ----------------------------------------------------------------------------
// tgb_datapath
// cursor state, offset arithmetic and output register of the blitter
// ----------------------------------------------------------------------------
module tgb_datapath #(
  parameter int COORD_BITS    = 12,
  parameter int MAX_GLYPH_DIM = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tgb_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  input  logic [tgb_pkg::CH_W-1:0]           in_ch,
  input  logic                               in_first_of_string,
  input  logic                               in_last_of_string,
  input  logic [tgb_pkg::XY_W-1:0]           in_start_x,
  input  logic [tgb_pkg::XY_W-1:0]           in_start_y,
  input  tgb_pkg::cmd_t                      cmd,
  output tgb_pkg::stat_t                     stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_kind,
  output logic [tgb_pkg::DEST_W-1:0]         out_dest_offset,
  output logic [tgb_pkg::SRC_W-1:0]          out_src_offset,
  output logic [tgb_pkg::DIM_W-1:0]          out_copy_len,
  output logic [tgb_pkg::XY_W-1:0]           out_damage_x,
  output logic [tgb_pkg::XY_W-1:0]           out_damage_y,
  output logic [tgb_pkg::XY_W-1:0]           out_damage_w,
  output logic [tgb_pkg::XY_W-1:0]           out_damage_h,
  output logic                               out_last
);

  localparam int CB     = COORD_BITS;
  localparam int PROD_W = CB + tgb_pkg::STRIDE_W;
  localparam int SRC2_W = tgb_pkg::SRC1_W + tgb_pkg::DIM_W;

  function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a,
                                            input logic [tgb_pkg::DIM_W-1:0] b);
    logic [CB:0] s;
    s = {1'b0, a} + (CB+1)'(b);
    sat_add = s[CB] ? {CB{1'b1}} : s[CB-1:0];
  endfunction

  // configuration
  logic [tgb_pkg::STRIDE_W-1:0] stride_r;
  logic [tgb_pkg::DIM_W-1:0]    gw_cfg_r, gh_cfg_r;
  logic [tgb_pkg::DIM_W-1:0]    gw, gh;

  // captured word
  logic [tgb_pkg::CH_W-1:0] ch_r;
  logic                     first_r, last_str_r;
  logic [tgb_pkg::XY_W-1:0] sx_r, sy_r;

  // text state
  logic [CB-1:0] origin_x_r, origin_y_r, cursor_x_r, cursor_y_r;
  logic [CB-1:0] line_w_r, max_w_r, text_h_r;

  // arithmetic
  logic [tgb_pkg::DEST_W-1:0] prod_dest_r, dest_r;
  logic [tgb_pkg::SRC1_W-1:0] src1_r;
  logic [tgb_pkg::SRC_W-1:0]  src_r;
  logic [tgb_pkg::DIM_W-1:0]  row_r;

  logic [CB-1:0]            cy_eff;
  logic [PROD_W-1:0]        prod_full;
  logic [SRC2_W-1:0]        src_full;
  logic [tgb_pkg::CH_W-1:0] glyph_idx;
  logic [CB-1:0]            line_w_new;

  // output register
  logic                       out_valid_r;
  logic                       kind_r, last_r;
  logic [tgb_pkg::DEST_W-1:0] odest_r;
  logic [tgb_pkg::SRC_W-1:0]  osrc_r;
  logic [tgb_pkg::DIM_W-1:0]  olen_r;
  logic [tgb_pkg::XY_W-1:0]   odx_r, ody_r, odw_r, odh_r;

  assign gw = ({1'b0, gw_cfg_r} > (tgb_pkg::DIM_W+1)'(MAX_GLYPH_DIM)) ?
              tgb_pkg::DIM_W'(MAX_GLYPH_DIM) : gw_cfg_r;
  assign gh = ({1'b0, gh_cfg_r} > (tgb_pkg::DIM_W+1)'(MAX_GLYPH_DIM)) ?
              tgb_pkg::DIM_W'(MAX_GLYPH_DIM) : gh_cfg_r;

  assign cy_eff     = first_r ? CB'(sy_r) : cursor_y_r;
  assign prod_full  = PROD_W'(cy_eff) * PROD_W'(stride_r);
  assign glyph_idx  = ch_r - tgb_pkg::CH_SPACE;
  assign src_full   = SRC2_W'(src1_r) * SRC2_W'(gh);
  assign line_w_new = sat_add(line_w_r, gw);

  always_comb begin
    stat           = '0;
    stat.printable = !ch_r[tgb_pkg::CH_W-1] && (ch_r >= tgb_pkg::CH_SPACE);
    stat.newline   = (ch_r == tgb_pkg::CH_NEWLINE);
    stat.gh_zero   = (gh == '0);
    stat.last_row  = (row_r == gh - tgb_pkg::DIM_W'(1));
    stat.last_str  = last_str_r;
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= tgb_pkg::RST_LINE_STRIDE;
      gw_cfg_r <= tgb_pkg::RST_GLYPH_WIDTH;
      gh_cfg_r <= tgb_pkg::RST_GLYPH_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgb_pkg::REG_LINE_STRIDE:  stride_r <= cfg_wdata;
        tgb_pkg::REG_GLYPH_WIDTH:  gw_cfg_r <= cfg_wdata[tgb_pkg::DIM_W-1:0];
        tgb_pkg::REG_GLYPH_HEIGHT: gh_cfg_r <= cfg_wdata[tgb_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ch_r       <= in_ch;
      first_r    <= in_first_of_string;
      last_str_r <= in_last_of_string;
      sx_r       <= in_start_x;
      sy_r       <= in_start_y;
    end
    if (cmd.setup) begin
      prod_dest_r <= tgb_pkg::DEST_W'(prod_full);
      src1_r      <= tgb_pkg::SRC1_W'(glyph_idx[tgb_pkg::GLYPH_IDX_W-1:0]) *
                     tgb_pkg::SRC1_W'(gw);
    end
    if (cmd.calc) begin
      dest_r <= prod_dest_r + tgb_pkg::DEST_W'(cursor_x_r);
      src_r  <= src_full[tgb_pkg::SRC_W-1:0];
      row_r  <= '0;
    end else if (cmd.row) begin
      dest_r <= dest_r + tgb_pkg::DEST_W'(stride_r);
      src_r  <= src_r + tgb_pkg::SRC_W'(gw);
      row_r  <= row_r + tgb_pkg::DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      line_w_r   <= '0;
      max_w_r    <= '0;
      text_h_r   <= '0;
    end else begin
      if (cmd.setup && first_r) begin
        origin_x_r <= CB'(sx_r);
        origin_y_r <= CB'(sy_r);
        cursor_x_r <= CB'(sx_r);
        cursor_y_r <= CB'(sy_r);
        line_w_r   <= '0;
        max_w_r    <= '0;
        text_h_r   <= sat_add('0, gh);
      end
      if (cmd.calc && stat.newline) begin
        line_w_r   <= '0;
        text_h_r   <= sat_add(text_h_r, gh);
        cursor_x_r <= origin_x_r;
        cursor_y_r <= cursor_y_r + CB'(gh);
      end
      if (cmd.adv) begin
        line_w_r   <= line_w_new;
        cursor_x_r <= cursor_x_r + CB'(gw);
        if (line_w_new > max_w_r) max_w_r <= line_w_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.row || cmd.dmg) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row) begin
      kind_r  <= tgb_pkg::KIND_ROW;
      odest_r <= dest_r;
      osrc_r  <= src_r;
      olen_r  <= gw;
      odx_r   <= '0;
      ody_r   <= '0;
      odw_r   <= '0;
      odh_r   <= '0;
      last_r  <= stat.last_row && !last_str_r;
    end else if (cmd.dmg) begin
      kind_r  <= tgb_pkg::KIND_DAMAGE;
      odest_r <= '0;
      osrc_r  <= '0;
      olen_r  <= '0;
      odx_r   <= tgb_pkg::XY_W'(origin_x_r);
      ody_r   <= tgb_pkg::XY_W'(origin_y_r);
      odw_r   <= tgb_pkg::XY_W'(max_w_r);
      odh_r   <= tgb_pkg::XY_W'(text_h_r);
      last_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_dest_offset = odest_r;
  assign out_src_offset  = osrc_r;
  assign out_copy_len    = olen_r;
  assign out_damage_x    = odx_r;
  assign out_damage_y    = ody_r;
  assign out_damage_w    = odw_r;
  assign out_damage_h    = odh_r;
  assign out_last        = last_r;

endmodule

FILE: rtl/core/text_glyph_blit_commands.sv
// ----------------------------------------------------------------------------
// text_glyph_blit_commands
// character-cell text blitter: turns text bytes into glyph row copy words
// and one damage rectangle word at the end of each string
// ----------------------------------------------------------------------------
//
//   port group | direction | handshake         | carries
//   -----------+-----------+-------------------+------------------------------
//   in_        | input     | in_valid/in_ready | text byte, string flags, origin
//   out_       | output    | out_valid/ready   | row copy or damage word
//   cfg_       | input     | cfg_we only       | stride, glyph width and height
//
// a byte is captured in the idle state, then the setup state applies the
// string start and forms the first products and the calc state finishes
// the offsets. a printable byte with a nonzero glyph height then goes
// through the row loop, one word per glyph row; any other byte skips it.
// the damage state adds one damage word after the last byte of a string.
// reset (rst_n low, synchronous) restores the register defaults and clears
// the cursor and size state. a stalled out_ready holds the row loop in place;
// the next byte is taken while the final word still waits in the output stage.
//
module text_glyph_blit_commands #(
  parameter int COORD_BITS    = 12,
  parameter int MAX_GLYPH_DIM = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [tgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgb_pkg::CFG_DAT_W-1:0] cfg_wdata,
  // text words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tgb_pkg::CH_W-1:0]      in_ch,
  input  logic                          in_first_of_string,
  input  logic                          in_last_of_string,
  input  logic [tgb_pkg::XY_W-1:0]      in_start_x,
  input  logic [tgb_pkg::XY_W-1:0]      in_start_y,
  // command words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [tgb_pkg::DEST_W-1:0]    out_dest_offset,
  output logic [tgb_pkg::SRC_W-1:0]     out_src_offset,
  output logic [tgb_pkg::DIM_W-1:0]     out_copy_len,
  output logic [tgb_pkg::XY_W-1:0]      out_damage_x,
  output logic [tgb_pkg::XY_W-1:0]      out_damage_y,
  output logic [tgb_pkg::XY_W-1:0]      out_damage_w,
  output logic [tgb_pkg::XY_W-1:0]      out_damage_h,
  output logic                          out_last
);

  // commands from the sequencer, status back from the datapath
  tgb_pkg::cmd_t  cmd;
  tgb_pkg::stat_t stat;

  // sequencer: capture, setup, offset calc, row loop, damage word
  tgb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: registers, cursor state, offset arithmetic, output stage
  tgb_datapath #(
    .COORD_BITS    (COORD_BITS),
    .MAX_GLYPH_DIM (MAX_GLYPH_DIM)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_ch              (in_ch),
    .in_first_of_string (in_first_of_string),
    .in_last_of_string  (in_last_of_string),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_dest_offset    (out_dest_offset),
    .out_src_offset     (out_src_offset),
    .out_copy_len       (out_copy_len),
    .out_damage_x       (out_damage_x),
    .out_damage_y       (out_damage_y),
    .out_damage_w       (out_damage_w),
    .out_damage_h       (out_damage_h),
    .out_last           (out_last)
  );

endmodule
